// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the epoch seconds converter.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CTE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define CTE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/cte_pkg.sv =====
// Constants, widths and month table for the calendar to epoch seconds converter.
// No dependencies.
`default_nettype none

package cte_pkg;

  // Field widths
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int OUT_W   = 33;

  // Internal widths
  localparam int DY_W    = 8;   // whole years since the epoch year
  localparam int LD_W    = 6;   // leap days in those years
  localparam int Q25_W   = 8;   // year / 25
  localparam int DOY_W   = 9;   // days before a month
  localparam int DAYS_W  = 17;  // total day count
  localparam int HMS_W   = 17;  // seconds within the day terms
  localparam int PROD_W  = 34;  // days * seconds per day, full width

  // Calendar constants
  localparam logic [YEAR_W-1:0] FIRST_YEAR   = 12'd1970;
  localparam logic [YEAR_W-1:0] LAST_YEAR    = 12'd2225;
  localparam logic [YEAR_W-1:0] CENT_A_YEAR  = 12'd2100;  // non-leap century
  localparam logic [YEAR_W-1:0] CENT_B_YEAR  = 12'd2200;  // non-leap century
  localparam logic [YEAR_W-1:0] LEAP_BASE    = 12'd492;   // 1969 / 4
  localparam logic [DOY_W-1:0]  DAYS_COMMON  = 9'd365;
  localparam logic [16:0]       SECS_PER_DAY = 17'd86400;
  localparam logic [11:0]       SECS_PER_HR  = 12'd3600;
  localparam logic [5:0]        SECS_PER_MIN = 6'd60;
  localparam logic [MONTH_W-1:0] ALL_MONTHS  = 4'd12;

  // year / 25 by reciprocal: (year * 5243) >> 17, exact for 12-bit years
  localparam logic [12:0] RECIP25       = 13'd5243;
  localparam int          RECIP25_SHIFT = 17;
  localparam logic [4:0]  TWENTY_FIVE   = 5'd25;

  // Days before the start of a month, by elapsed months, common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] elapsed);
    logic [DOY_W-1:0] d;
    case (elapsed)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/calendar_to_epoch_seconds_top.sv =====
// Calendar to epoch seconds converter, four-stage pipeline.
// Depends on cte_pkg and assert_macros.svh.
`default_nettype none
//
// Usage:
//   A request on the in_ channel carries a UTC date and time (year, month,
//   day, hours, minutes, seconds). It is taken at a clock edge where
//   in_valid is high and in_stall is low. Each request gives one result on
//   the out_ channel: out_epoch_seconds, seconds since 1970-01-01 00:00:00.
//   Years after 2225 give all ones.
//   The request passes the four stage registers (decode, day count, day-to-
//   seconds multiply, output sum) in that order; out_valid rises when it
//   reaches the last. One request can be taken every cycle while out_stall
//   is low.
//   When the receiver raises out_stall the result register holds; stages
//   behind it keep filling empty slots, and in_stall rises only once every
//   stage holds a request.
//   Reset (rst_n low, synchronous) empties the pipeline; payload registers
//   are not cleared.
//

module calendar_to_epoch_seconds_top (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [cte_pkg::YEAR_W-1:0]       in_year,
  input  wire  [cte_pkg::MONTH_W-1:0]      in_month,
  input  wire  [cte_pkg::DAY_W-1:0]        in_day,
  input  wire  [cte_pkg::HOUR_W-1:0]       in_hours,
  input  wire  [cte_pkg::MIN_W-1:0]        in_minutes,
  input  wire  [cte_pkg::SEC_W-1:0]        in_seconds,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [cte_pkg::OUT_W-1:0]        out_epoch_seconds
);

`include "assert_macros.svh"

  localparam int HMS_W  = cte_pkg::HMS_W;
  localparam int DAYS_W = cte_pkg::DAYS_W;

  // Stage valids and enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall  = !en1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------- Stage 1: field decode ----------------
  logic                              sat1_nxt, sat1_r;
  logic [cte_pkg::DY_W-1:0]          dy1_nxt, dy1_r;
  logic [cte_pkg::LD_W-1:0]          ld1_nxt, ld1_r;
  logic [cte_pkg::Q25_W-1:0]         q251_nxt, q251_r;
  logic [cte_pkg::YEAR_W-1:0]        year1_r;
  logic [cte_pkg::MONTH_W-1:0]       el1_nxt, el1_r;
  logic [cte_pkg::DAY_W-1:0]         dt1_nxt, dt1_r;
  logic [cte_pkg::HMS_W-1:0]         hms1_nxt, hms1_r;
  logic [cte_pkg::YEAR_W-1:0]        ydiff, yquart, ldwide;
  logic [24:0]                       recip_prod;

  always_comb begin
    sat1_nxt = (in_year > cte_pkg::LAST_YEAR);
    // whole years and leap days since the epoch year
    ydiff  = in_year - cte_pkg::FIRST_YEAR;
    yquart = (in_year - 12'd1) >> 2;
    ldwide = yquart - cte_pkg::LEAP_BASE
           - {11'd0, (in_year > cte_pkg::CENT_A_YEAR)}
           - {11'd0, (in_year > cte_pkg::CENT_B_YEAR)};
    if (in_year > cte_pkg::FIRST_YEAR) begin
      dy1_nxt = ydiff[cte_pkg::DY_W-1:0];
      ld1_nxt = ldwide[cte_pkg::LD_W-1:0];
    end else begin
      dy1_nxt = '0;
      ld1_nxt = '0;
    end
    // year / 25 for the century test
    recip_prod = {13'd0, in_year} * {12'd0, cte_pkg::RECIP25};
    q251_nxt   = recip_prod[cte_pkg::RECIP25_SHIFT +: cte_pkg::Q25_W];
    // elapsed months, clamped to a full year
    if (in_month == '0)                     el1_nxt = '0;
    else if (in_month > cte_pkg::ALL_MONTHS) el1_nxt = cte_pkg::ALL_MONTHS;
    else                                     el1_nxt = in_month - 4'd1;
    // day zero counts as day one
    dt1_nxt = (in_day == '0) ? '0 : in_day - 5'd1;
    // hours, minutes and seconds within the day
    hms1_nxt = HMS_W'({12'd0, in_hours} * {5'd0, cte_pkg::SECS_PER_HR})
             + HMS_W'({6'd0, in_minutes} * {6'd0, cte_pkg::SECS_PER_MIN})
             + HMS_W'(in_seconds);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sat1_r  <= sat1_nxt;
      dy1_r   <= dy1_nxt;
      ld1_r   <= ld1_nxt;
      q251_r  <= q251_nxt;
      year1_r <= in_year;
      el1_r   <= el1_nxt;
      dt1_r   <= dt1_nxt;
      hms1_r  <= hms1_nxt;
    end
  end

  // ---------------- Stage 2: day count ----------------
  logic                         sat2_r;
  logic [cte_pkg::DAYS_W-1:0]   days2_nxt, days2_r;
  logic [HMS_W-1:0]             hms2_r;
  logic [cte_pkg::YEAR_W-1:0]   q25x25;
  logic                         m4, m16, m25, leap;

  always_comb begin
    q25x25 = ({4'd0, q251_r} << 4) + ({4'd0, q251_r} << 3) + {4'd0, q251_r};
    m4   = (year1_r[1:0] == 2'd0);
    m16  = (year1_r[3:0] == 4'd0);
    m25  = (q25x25 == year1_r);
    leap = m4 && (!m25 || m16);
    days2_nxt = DAYS_W'({9'd0, dy1_r} * {8'd0, cte_pkg::DAYS_COMMON})
              + DAYS_W'(ld1_r)
              + DAYS_W'(cte_pkg::days_before(el1_r))
              + DAYS_W'(leap && (el1_r >= 4'd2))
              + DAYS_W'(dt1_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sat2_r  <= sat1_r;
      days2_r <= days2_nxt;
      hms2_r  <= hms1_r;
    end
  end

  // ---------------- Stage 3: days to seconds ----------------
  logic                        sat3_r;
  logic [cte_pkg::PROD_W-1:0]  prod3_nxt, prod3_r;
  logic [HMS_W-1:0]            hms3_r;

  assign prod3_nxt = {17'd0, days2_r} * {17'd0, cte_pkg::SECS_PER_DAY};

  always_ff @(posedge clk) begin
    if (en3) begin
      sat3_r  <= sat2_r;
      prod3_r <= prod3_nxt;
      hms3_r  <= hms2_r;
    end
  end

  // ---------------- Stage 4: final sum and result register ----------------
  logic [cte_pkg::OUT_W-1:0] out_nxt, out_r;

  always_comb begin
    if (sat3_r) out_nxt = '1;
    else        out_nxt = prod3_r[cte_pkg::OUT_W-1:0]
                        + {{(cte_pkg::OUT_W-HMS_W){1'b0}}, hms3_r};
  end

  always_ff @(posedge clk) begin
    if (en4) out_r <= out_nxt;
  end

  assign out_epoch_seconds = out_r;

  // ---------------- Checks ----------------
  // in_stall only when every stage is full and the output is held
  `CTE_ASSERT_NOW(a_stall_full, in_stall, v1_r && v2_r && v3_r && out_valid && out_stall)
  // an out-of-range year is flagged for saturation in stage 1
  `CTE_ASSERT_NEXT(a_sat_flag, in_valid && !in_stall && (in_year > cte_pkg::LAST_YEAR), v1_r && sat1_r)
  // a saturated request reaches the output as all ones
  `CTE_ASSERT_NEXT(a_sat_out, v3_r && sat3_r && en4, out_valid && (&out_epoch_seconds))
  // a request held in stage 3 is not dropped
  `CTE_ASSERT_NEXT(a_hold3, v3_r && !en4, v3_r)

endmodule

`default_nettype wire

// ===== tb/calendar_to_epoch_seconds_top_test.sv =====
// Self-checking testbench for calendar_to_epoch_seconds_top: directed and random date requests.
// Depends on cte_pkg and the RTL of the converter; the scoreboard predicts every result itself.
`default_nettype none

module calendar_to_epoch_seconds_top_test;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned ITEMS_PER_PHASE = 610;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Field types of a request and a result
  typedef logic [cte_pkg::YEAR_W-1:0]  year_t;
  typedef logic [cte_pkg::MONTH_W-1:0] month_t;
  typedef logic [cte_pkg::DAY_W-1:0]   day_t;
  typedef logic [cte_pkg::HOUR_W-1:0]  hour_t;
  typedef logic [cte_pkg::MIN_W-1:0]   min_t;
  typedef logic [cte_pkg::SEC_W-1:0]   sec_t;
  typedef logic [cte_pkg::OUT_W-1:0]   epoch_t;

  // Expected epoch seconds for every accepted request, oldest first
  class epoch_scoreboard;
    epoch_t pending_epochs[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // Seconds since 1970-01-01 00:00:00 for a broken-down date and time
    function epoch_t epoch_from_calendar(input year_t yr, input month_t mo, input day_t dy,
                                         input hour_t hr, input min_t mi, input sec_t sc);
      longint unsigned month_start[13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                           334, 365};
      longint unsigned day_count;
      longint unsigned total;
      int unsigned months_done;
      bit leap;
      if (yr > cte_pkg::LAST_YEAR)
        return '1;
      day_count = 0;
      if (yr > cte_pkg::FIRST_YEAR)
        day_count = 365 * (yr - cte_pkg::FIRST_YEAR) + leap_days_through(yr - 1)
                    - leap_days_through(cte_pkg::FIRST_YEAR - 1);
      months_done = (mo == 0) ? 0 : mo - 1;
      if (months_done > 12)
        months_done = 12;
      day_count += month_start[months_done];
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      if (months_done >= 2 && leap)
        day_count += 1;
      if (dy > 0)
        day_count += dy - 1;
      total = day_count * cte_pkg::SECS_PER_DAY + hr * cte_pkg::SECS_PER_HR
              + mi * cte_pkg::SECS_PER_MIN + sc;
      return total[cte_pkg::OUT_W-1:0];
    endfunction

    // Leap years in 1..n
    function longint unsigned leap_days_through(input longint unsigned n);
      return n / 4 - n / 100 + n / 400;
    endfunction

    function void note_request(input year_t yr, input month_t mo, input day_t dy,
                               input hour_t hr, input min_t mi, input sec_t sc);
      pending_epochs.push_back(epoch_from_calendar(yr, mo, dy, hr, mi, sc));
    endfunction

    function void check_result(input epoch_t got);
      epoch_t want;
      if (pending_epochs.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: epoch_seconds %0d with no request pending", got);
        return;
      end
      want = pending_epochs.pop_front();
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("epoch_seconds mismatch: expected %0d, got %0d", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  year_t in_year = '0;
  month_t in_month = '0;
  day_t in_day = '0;
  hour_t in_hours = '0;
  min_t in_minutes = '0;
  sec_t in_seconds = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  epoch_t out_epoch_seconds;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit pressure_on = 1'b0;
  int unsigned cycle_count = 0;
  epoch_scoreboard sb = new();

  calendar_to_epoch_seconds_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day           (in_day),
    .in_hours         (in_hours),
    .in_minutes       (in_minutes),
    .in_seconds       (in_seconds),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_epoch_seconds(out_epoch_seconds)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("calendar_to_epoch_seconds_top_test failed");
      $finish;
    end
  end

  // Offer one request after optional idle cycles; returns once it is accepted
  task automatic send_request(input year_t yr, input month_t mo, input day_t dy,
                              input hour_t hr, input min_t mi, input sec_t sc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_year <= yr;
    in_month <= mo;
    in_day <= dy;
    in_hours <= hr;
    in_minutes <= mi;
    in_seconds <= sc;
    do
      @(posedge clk);
    while (in_stall);
    sb.note_request(yr, mo, dy, hr, mi, sc);
  endtask

  // Result side: check accepted results, stall at random, one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_epoch_seconds);
      if (pressure_on && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Stimulus and end of run
  initial begin : sender
    int unsigned phase;
    int unsigned idx;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range ends, saturation, leap rule, odd months and days
    send_idle_pct = 10;
    recv_idle_pct = 70;
    send_request(12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2225, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_request(12'd2226, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_request(12'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_request(12'd1969, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd1968, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd1972, 4'd2, 5'd29, 5'd12, 6'd30, 6'd30);
    send_request(12'd1972, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2000, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2200, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2024, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    send_request(12'd2023, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0);
    send_request(12'd2024, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_request(12'd2225, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_request(12'd1970, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_request(12'd2001, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0);
    send_request(12'd2047, 4'd7, 5'd15, 5'd8, 6'd45, 6'd10);
    send_request(12'd1985, 4'd10, 5'd26, 5'd1, 6'd21, 6'd0);

    // Random: mostly valid dates, some raw noise over the full field widths
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 10;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 10;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          pressure_on = 1'b1;
        end
      endcase
      for (idx = 0; idx < ITEMS_PER_PHASE; idx++) begin
        if ($urandom_range(99) < 80)
          send_request(year_t'($urandom_range(2225, 1970)), month_t'($urandom_range(12, 1)),
                       day_t'($urandom_range(31, 1)), hour_t'($urandom_range(23)),
                       min_t'($urandom_range(59)), sec_t'($urandom_range(59)));
        else if ($urandom_range(1))
          send_request(year_t'($urandom_range(2300, 1900)), month_t'($urandom_range(15)),
                       day_t'($urandom_range(31)), hour_t'($urandom_range(31)),
                       min_t'($urandom_range(63)), sec_t'($urandom_range(63)));
        else
          send_request(year_t'($urandom_range(4095)), month_t'($urandom_range(15)),
                       day_t'($urandom_range(31)), hour_t'($urandom_range(31)),
                       min_t'($urandom_range(63)), sec_t'($urandom_range(63)));
      end
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then allow the pipeline to settle
    while (sb.pending_epochs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fails == 0)
      $display("calendar_to_epoch_seconds_top_test passed");
    else
      $display("calendar_to_epoch_seconds_top_test failed");
    $finish;
  end

endmodule

`default_nettype wire
